// ===== rtl/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg: shared types and constants of the sorted delay timer queue
// Field widths, command codes, sequencer states and the stored entry layout.
// ----------------------------------------------------------------------------
package sdtq_pkg;

   localparam int CMD_W   = 2;
   localparam int TIME_W  = 32;
   localparam int ID_W    = 32;
   localparam int WIN_W   = 32;
   localparam int MASK_W  = 64;
   localparam int ETYPE_W = 6;
   localparam int CNT_W   = 5;   // width of the removed_count and occupancy fields

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_ADD    = 2'd0;
   localparam cmd_type CMD_TICK   = 2'd1;
   localparam cmd_type CMD_CANCEL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] remaining;
      logic [ID_W-1:0]   target;
      logic [WIN_W-1:0]  window;
      logic [MASK_W-1:0] breaks;
   } entry_type;

endpackage

// ===== rtl/sdtq_req_if.sv =====
// ----------------------------------------------------------------------------
// sdtq_req_if: command channel of the timer queue
// Valid/ready channel carrying one timer command per transaction.
// ----------------------------------------------------------------------------
interface sdtq_req_if;
   logic                             valid;
   logic                             ready;
   sdtq_pkg::cmd_type                cmd;
   logic [sdtq_pkg::TIME_W-1:0]      delay_us;
   logic [sdtq_pkg::ID_W-1:0]        target_id;
   logic [sdtq_pkg::WIN_W-1:0]       match_window;
   logic [sdtq_pkg::MASK_W-1:0]      break_mask;
   logic [sdtq_pkg::ETYPE_W-1:0]     event_type;

   modport source (
      output valid, cmd, delay_us, target_id, match_window, break_mask, event_type,
      input  ready
   );
   modport sink (
      input  valid, cmd, delay_us, target_id, match_window, break_mask, event_type,
      output ready
   );
endinterface

// ===== rtl/sdtq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sdtq_rsp_if: result channel of the timer queue
// Valid/ready channel carrying one result per command transaction.
// ----------------------------------------------------------------------------
interface sdtq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          fired;
   logic [sdtq_pkg::ID_W-1:0]     fired_id;
   logic                          status;
   logic [sdtq_pkg::CNT_W-1:0]    removed_count;
   logic [sdtq_pkg::CNT_W-1:0]    occupancy;

   modport source (
      output valid, fired, fired_id, status, removed_count, occupancy,
      input  ready
   );
   modport sink (
      input  valid, fired, fired_id, status, removed_count, occupancy,
      output ready
   );
endinterface

// ===== rtl/sdtq_entry_ram.sv =====
// ----------------------------------------------------------------------------
// sdtq_entry_ram: timer entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdtq_entry_ram #(
   parameter  int DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  sdtq_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output sdtq_pkg::entry_type rd_data
);

   sdtq_pkg::entry_type mem [DEPTH];
   sdtq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sorted_delay_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_delay_timer_queue_unit: sorted queue of pending microsecond timers
// Holds up to DEPTH timers in order of remaining time; add, tick and cancel.
// ----------------------------------------------------------------------------
// One command transaction is taken at a time and yields exactly one result.
// The entries live in a single-port-read memory; a tick or cancel walks all
// occupied entries through that one read port, one entry per cycle, and an
// add walks from the tail until its slot is found, with the read data
// registered; an entry is rewritten (moved, decremented or dropped) in the
// cycle after it is read. An add on an empty queue writes the new timer
// straight to the front; otherwise it moves later entries up and lands
// behind the first entry that is not later, or at the front. A tick or
// cancel on an empty queue, a rejected add or an unused command code goes
// straight to the result. A result is loaded only once the previous one
// has been taken. The result sits in an output register, so a new command is
// accepted as soon as the walk is done and the result has been loaded, even
// if that result has not yet been taken. Memory contents need no clearing
// after reset: only entries below the occupancy count are ever read.
// ----------------------------------------------------------------------------
module sorted_delay_timer_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   sdtq_req_if.sink   req_bus,
   sdtq_rsp_if.source rsp_bus
);

   localparam int IW = $clog2(DEPTH);       // entry index
   localparam int CW = $clog2(DEPTH + 1);   // occupancy, 0..DEPTH

   // --- sequencer state ---
   sdtq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       iss_idx_ff, iss_idx_in;     // next read address
   logic [CW-1:0]       iss_left_ff, iss_left_in;   // reads still to issue
   logic                pv_ff, pv_in;               // read data valid
   logic [IW-1:0]       proc_idx_ff, proc_idx_in;   // index of read data
   logic                proc_last_ff, proc_last_in;

   // --- latched command transaction ---
   sdtq_pkg::cmd_type            cmd_ff, cmd_in;
   sdtq_pkg::entry_type          new_ff, new_in;
   logic [sdtq_pkg::ETYPE_W-1:0] etype_ff, etype_in;

   // --- per-command scratch ---
   logic                       fire_ff, fire_in;
   logic [sdtq_pkg::ID_W-1:0]  fired_id_ff, fired_id_in;
   logic                       status_ff, status_in;
   logic [CW-1:0]              keep_ff, keep_in;
   logic [CW-1:0]              removed_ff, removed_in;

   // --- result register ---
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_fired_ff, rsp_fired_in;
   logic [sdtq_pkg::ID_W-1:0]  rsp_fired_id_ff, rsp_fired_id_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic [sdtq_pkg::CNT_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [sdtq_pkg::CNT_W-1:0] rsp_occ_ff, rsp_occ_in;

   // --- memory port ---
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   sdtq_pkg::entry_type wr_data;
   logic                rd_en;
   logic [IW-1:0]       rd_addr;
   sdtq_pkg::entry_type rd_data;

   // --- decisions on the entry just read ---
   logic                later;      // entry stays behind the new timer
   logic                is_head;
   logic                fire_now;   // head entry expires on this tick
   logic                shift;      // tick: entries move down one slot
   logic                hit;        // cancel matches this entry
   sdtq_pkg::entry_type dec_entry;
   logic [CW+sdtq_pkg::CNT_W-1:0] removed_ext;
   logic [CW+sdtq_pkg::CNT_W-1:0] count_ext;

   sdtq_entry_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign later    = rd_data.remaining > new_ff.remaining;
   assign is_head  = proc_idx_ff == '0;
   assign fire_now = is_head && (rd_data.remaining <= sdtq_pkg::TIME_W'(1));
   assign shift    = is_head ? fire_now : fire_ff;
   assign hit      = (rd_data.window == new_ff.window) && rd_data.breaks[etype_ff];

   always_comb begin
      dec_entry = rd_data;
      if (rd_data.remaining != '0) begin
         dec_entry.remaining = rd_data.remaining - sdtq_pkg::TIME_W'(1);
      end
   end

   // Result fields are 5 bits wide; wider counts are truncated, narrower ones padded.
   assign removed_ext = (CW + sdtq_pkg::CNT_W)'(removed_ff);
   assign count_ext   = (CW + sdtq_pkg::CNT_W)'(count_ff);

   assign req_bus.ready         = state_ff == sdtq_pkg::ST_IDLE;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.fired         = rsp_fired_ff;
   assign rsp_bus.fired_id      = rsp_fired_id_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.removed_count = rsp_removed_ff;
   assign rsp_bus.occupancy     = rsp_occ_ff;

   // Sequencer: next state, memory port and per-entry processing.
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      iss_idx_in      = iss_idx_ff;
      iss_left_in     = iss_left_ff;
      pv_in           = 1'b0;
      proc_idx_in     = proc_idx_ff;
      proc_last_in    = proc_last_ff;
      cmd_in          = cmd_ff;
      new_in          = new_ff;
      etype_in        = etype_ff;
      fire_in         = fire_ff;
      fired_id_in     = fired_id_ff;
      status_in       = status_ff;
      keep_in         = keep_ff;
      removed_in      = removed_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_fired_in    = rsp_fired_ff;
      rsp_fired_id_in = rsp_fired_id_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_removed_in  = rsp_removed_ff;
      rsp_occ_in      = rsp_occ_ff;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = rd_data;
      rd_en           = 1'b0;
      rd_addr         = iss_idx_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sdtq_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in             = req_bus.cmd;
               new_in.remaining   = req_bus.delay_us;
               new_in.target      = req_bus.target_id;
               new_in.window      = req_bus.match_window;
               new_in.breaks      = req_bus.break_mask;
               etype_in           = req_bus.event_type;
               fire_in            = 1'b0;
               fired_id_in        = '0;
               status_in          = 1'b0;
               keep_in            = '0;
               removed_in         = '0;
               iss_left_in        = count_ff;
               iss_idx_in         = '0;
               state_in           = sdtq_pkg::ST_FINISH;
               case (req_bus.cmd)
                  sdtq_pkg::CMD_ADD: begin
                     // walk from the tail towards the head, moving later entries up
                     if (count_ff >= CW'(DEPTH)) begin
                        status_in   = 1'b1;
                        iss_left_in = '0;
                     end else if (count_ff == '0) begin
                        state_in = sdtq_pkg::ST_INSERT;
                     end else begin
                        iss_idx_in = IW'(count_ff - CW'(1));
                        state_in   = sdtq_pkg::ST_SCAN;
                     end
                  end
                  sdtq_pkg::CMD_TICK, sdtq_pkg::CMD_CANCEL: begin
                     if (count_ff != '0) begin
                        state_in = sdtq_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     iss_left_in = '0;
                  end
               endcase
            end
         end

         sdtq_pkg::ST_SCAN: begin
            // issue the next read
            if (iss_left_ff != '0) begin
               rd_en        = 1'b1;
               pv_in        = 1'b1;
               proc_idx_in  = iss_idx_ff;
               proc_last_in = iss_left_ff == CW'(1);
               iss_left_in  = iss_left_ff - CW'(1);
               if (cmd_ff == sdtq_pkg::CMD_ADD) begin
                  iss_idx_in = iss_idx_ff - IW'(1);
               end else begin
                  iss_idx_in = iss_idx_ff + IW'(1);
               end
            end

            // process the entry read last cycle
            if (pv_ff) begin
               case (cmd_ff)
                  sdtq_pkg::CMD_ADD: begin
                     wr_en   = 1'b1;
                     wr_addr = IW'(proc_idx_ff + IW'(1));
                     if (later) begin
                        wr_data = rd_data;
                        if (proc_last_ff) begin
                           state_in = sdtq_pkg::ST_INSERT;
                        end
                     end else begin
                        // slot found: drop the read already in flight
                        wr_data     = new_ff;
                        count_in    = count_ff + CW'(1);
                        rd_en       = 1'b0;
                        pv_in       = 1'b0;
                        iss_left_in = '0;
                        state_in    = sdtq_pkg::ST_FINISH;
                     end
                  end
                  sdtq_pkg::CMD_TICK: begin
                     wr_en   = !fire_now;
                     wr_addr = IW'(proc_idx_ff - IW'(shift));
                     wr_data = dec_entry;
                     if (is_head) begin
                        fire_in = fire_now;
                        if (fire_now) begin
                           fired_id_in = rd_data.target;
                        end
                     end
                     if (proc_last_ff) begin
                        count_in = count_ff - CW'(shift);
                        state_in = sdtq_pkg::ST_FINISH;
                     end
                  end
                  sdtq_pkg::CMD_CANCEL: begin
                     if (hit) begin
                        removed_in = removed_ff + CW'(1);
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = keep_ff[IW-1:0];
                        keep_in = keep_ff + CW'(1);
                     end
                     if (proc_last_ff) begin
                        count_in = keep_in;
                        state_in = sdtq_pkg::ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = sdtq_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         sdtq_pkg::ST_INSERT: begin
            // new timer goes to the front
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = new_ff;
            count_in = count_ff + CW'(1);
            state_in = sdtq_pkg::ST_FINISH;
         end

         sdtq_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_fired_in    = fire_ff;
               rsp_fired_id_in = fired_id_ff;
               rsp_status_in   = status_ff;
               rsp_removed_in  = removed_ext[sdtq_pkg::CNT_W-1:0];
               rsp_occ_in      = count_ext[sdtq_pkg::CNT_W-1:0];
               state_in        = sdtq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sdtq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdtq_pkg::ST_IDLE;
         count_ff     <= '0;
         iss_left_ff  <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_left_ff  <= iss_left_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_idx_ff      <= iss_idx_in;
      proc_idx_ff     <= proc_idx_in;
      proc_last_ff    <= proc_last_in;
      cmd_ff          <= cmd_in;
      new_ff          <= new_in;
      etype_ff        <= etype_in;
      fire_ff         <= fire_in;
      fired_id_ff     <= fired_id_in;
      status_ff       <= status_in;
      keep_ff         <= keep_in;
      removed_ff      <= removed_in;
      rsp_fired_ff    <= rsp_fired_in;
      rsp_fired_id_ff <= rsp_fired_id_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_removed_ff  <= rsp_removed_in;
      rsp_occ_ff      <= rsp_occ_in;
   end

   // --- assertions ---
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff != sdtq_pkg::ST_IDLE))
      else $error("command transaction accepted but sequencer stayed idle");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy beyond queue depth");

   a_fire_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdtq_pkg::ST_FINISH && fire_ff) |-> (cmd_ff == sdtq_pkg::CMD_TICK))
      else $error("timer fired on a command other than a tick");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdtq_pkg::ST_FINISH && status_ff) |-> (count_ff == CW'(DEPTH)))
      else $error("add rejected while the queue had room");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < 32'(DEPTH)))
      else $error("entry write outside the store");

endmodule
